FILE: src/swsf_pkg.sv
// ----------------------------------------------------------------------------
// swsf_pkg
// Shared widths, codes and types of the sliding window segment fetcher.
// ----------------------------------------------------------------------------
package swsf_pkg;

  localparam int WINDOW_DEF        = 16;
  localparam int SEGMENT_BYTES_DEF = 1000;

  localparam int SLOT_W     = 4;
  localparam int RING_SLOTS = 1 << SLOT_W;
  localparam int COUNT_W    = SLOT_W + 1;
  localparam int REQ_W      = 2;
  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 16;
  localparam int OFF_W      = 32;
  localparam int DLEN_W     = 16;
  localparam int LEN_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // input item codes
  localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DATA    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_GET     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_PORT = 2'd2;

  typedef struct packed {
    logic [OFF_W-1:0]  file_size;
    logic [ADDR_W-1:0] server_addr;
    logic [PORT_W-1:0] server_port;
  } cfg_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] len;
  } slot_entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    slot_entry_t       wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: src/swsf_if.sv
// ----------------------------------------------------------------------------
// swsf channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface swsf_in_if;
  import swsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] sender_addr;
  logic [PORT_W-1:0] sender_port;
  logic              header_ok;
  logic [OFF_W-1:0]  data_offset;
  logic [DLEN_W-1:0] data_length;

  modport source (
    output valid, req_type, sender_addr, sender_port, header_ok, data_offset,
           data_length,
    input  ready
  );
  modport sink (
    input  valid, req_type, sender_addr, sender_port, header_ok, data_offset,
           data_length,
    output ready
  );
endinterface

interface swsf_out_if;
  import swsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic [OFF_W-1:0]  seg_offset;
  logic [LEN_W-1:0]  seg_bytes;
  logic [OFF_W-1:0]  bytes_done;
  logic              done_res;
  logic              last;

  modport source (
    output valid, kind, slot, seg_offset, seg_bytes, bytes_done, done_res, last,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, seg_offset, seg_bytes, bytes_done, done_res, last,
    output ready
  );
endinterface

FILE: src/swsf_slot_mem.sv
// ----------------------------------------------------------------------------
// swsf_slot_mem
// Ring slot table: offset and length of each open segment, one write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
module swsf_slot_mem (
  input  logic                   clk,
  input  swsf_pkg::mem_req_t     req,
  output swsf_pkg::slot_entry_t  rdata
);
  import swsf_pkg::*;

  slot_entry_t mem [RING_SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

FILE: src/swsf_seq.sv
// ----------------------------------------------------------------------------
// swsf_seq
// Window sequencer: walks the slot table one entry at a time, keeps the
// received flags and window pointers, and drives the result register.
// ----------------------------------------------------------------------------
module swsf_seq #(
  parameter int WINDOW        = swsf_pkg::WINDOW_DEF,
  parameter int SEGMENT_BYTES = swsf_pkg::SEGMENT_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  swsf_pkg::cfg_t        cfg,
  swsf_in_if.sink               item,
  swsf_out_if.source            result,
  output swsf_pkg::mem_req_t    mem_req,
  input  swsf_pkg::slot_entry_t mem_rdata
);
  import swsf_pkg::*;

  localparam int CapInt = (WINDOW > RING_SLOTS) ? RING_SLOTS : WINDOW;
  localparam logic [COUNT_W-1:0] Cap      = COUNT_W'(CapInt);
  localparam logic [OFF_W-1:0]   SegBytes = OFF_W'(SEGMENT_BYTES);
  localparam logic [LEN_W-1:0]   SegLen   = LEN_W'(SEGMENT_BYTES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_OPEN   = 3'd1;
  localparam logic [2:0] S_TO_RD  = 3'd2;
  localparam logic [2:0] S_TO_EM  = 3'd3;
  localparam logic [2:0] S_SC_RD  = 3'd4;
  localparam logic [2:0] S_SC_CMP = 3'd5;
  localparam logic [2:0] S_DCHK   = 3'd6;
  localparam logic [2:0] S_DEMIT  = 3'd7;

  logic [2:0]            st;
  logic                  open_ret;   // open issued from the delivery loop
  logic [COUNT_W-1:0]    idx;
  logic [SLOT_W-1:0]     head;
  logic [COUNT_W-1:0]    win_count;
  logic [OFF_W-1:0]      req_bytes;
  logic [OFF_W-1:0]      delivered;
  logic [RING_SLOTS-1:0] rcv;
  logic [OFF_W-1:0]      data_off;
  logic [DLEN_W-1:0]     data_len;

  logic                  res_valid;
  logic [KIND_W-1:0]     res_kind;
  logic [SLOT_W-1:0]     res_slot;
  logic [OFF_W-1:0]      res_off;
  logic [LEN_W-1:0]      res_len;
  logic [OFF_W-1:0]      res_done_bytes;
  logic                  res_done;
  logic                  res_last;

  logic                  emit_ok;
  logic [SLOT_W-1:0]     scan_slot;
  logic [SLOT_W-1:0]     open_slot;
  logic [SLOT_W-1:0]     head_plus1;
  logic                  need_more;
  logic                  can_open;
  logic [OFF_W-1:0]      left;
  logic [LEN_W-1:0]      seg;
  logic                  more_after_open;
  logic                  sender_ok;
  logic                  hit;
  logic [OFF_W-1:0]      deliv_sum;
  logic                  scan_end;

  assign emit_ok    = !res_valid || result.ready;
  assign scan_slot  = head + idx[SLOT_W-1:0];
  assign open_slot  = head + win_count[SLOT_W-1:0];
  assign head_plus1 = head + SLOT_W'(1);
  assign need_more  = req_bytes < cfg.file_size;
  assign can_open   = need_more && (win_count < Cap);
  assign left       = cfg.file_size - req_bytes;
  assign seg        = (left < SegBytes) ? left[LEN_W-1:0] : SegLen;
  assign more_after_open = (left > SegBytes) && ((win_count + COUNT_W'(1)) < Cap);
  assign sender_ok  = item.header_ok && (item.sender_addr == cfg.server_addr) &&
                      (item.sender_port == cfg.server_port);
  assign hit        = (mem_rdata.offset == data_off) &&
                      (data_len[DLEN_W-1:LEN_W] == '0) &&
                      (mem_rdata.len == data_len[LEN_W-1:0]) && !rcv[scan_slot];
  assign deliv_sum  = delivered + {{(OFF_W-LEN_W){1'b0}}, mem_rdata.len};
  assign scan_end   = (idx == win_count - COUNT_W'(1));

  assign mem_req.we           = (st == S_OPEN) && can_open && emit_ok;
  assign mem_req.waddr        = open_slot;
  assign mem_req.wdata.offset = req_bytes;
  assign mem_req.wdata.len    = seg;
  assign mem_req.raddr        = (st == S_DCHK || st == S_DEMIT) ? head : scan_slot;

  assign item.ready        = (st == S_IDLE);
  assign result.valid      = res_valid;
  assign result.kind       = res_kind;
  assign result.slot       = res_slot;
  assign result.seg_offset = res_off;
  assign result.seg_bytes  = res_len;
  assign result.bytes_done = res_done_bytes;
  assign result.done_res   = res_done;
  assign result.last       = res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      open_ret  <= 1'b0;
      idx       <= '0;
      head      <= '0;
      win_count <= '0;
      req_bytes <= '0;
      delivered <= '0;
      rcv       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (item.valid) begin
            data_off <= item.data_offset;
            data_len <= item.data_length;
            idx      <= '0;
            open_ret <= 1'b0;
            unique case (item.req_type)
              REQ_START: begin
                st <= S_OPEN;
              end
              REQ_TIMEOUT: begin
                if (win_count != '0) st <= S_TO_RD;
              end
              REQ_DATA: begin
                st <= (sender_ok && win_count != '0) ? S_SC_RD : S_DCHK;
              end
              default: ;
            endcase
          end
        end
        S_OPEN: begin
          if (!can_open) begin
            st <= open_ret ? S_DCHK : S_IDLE;
          end else if (emit_ok) begin
            res_valid      <= 1'b1;
            res_kind       <= KIND_GET;
            res_slot       <= open_slot;
            res_off        <= req_bytes;
            res_len        <= seg;
            res_done_bytes <= delivered;
            res_done       <= 1'b0;
            // after a refill the loop goes on only if the head is already in
            res_last       <= open_ret ? !(win_count != '0 && rcv[head])
                                       : !more_after_open;
            rcv[open_slot] <= 1'b0;
            win_count      <= win_count + COUNT_W'(1);
            req_bytes      <= req_bytes + {{(OFF_W-LEN_W){1'b0}}, seg};
            if (open_ret) begin
              st <= S_DCHK;
            end else if (!more_after_open) begin
              st <= S_IDLE;
            end
          end
        end
        S_TO_RD: begin
          st <= S_TO_EM;
        end
        S_TO_EM: begin
          if (emit_ok) begin
            res_valid      <= 1'b1;
            res_kind       <= KIND_GET;
            res_slot       <= scan_slot;
            res_off        <= mem_rdata.offset;
            res_len        <= mem_rdata.len;
            res_done_bytes <= delivered;
            res_done       <= 1'b0;
            res_last       <= scan_end;
            if (scan_end) begin
              st <= S_IDLE;
            end else begin
              idx <= idx + COUNT_W'(1);
              st  <= S_TO_RD;
            end
          end
        end
        S_SC_RD: begin
          st <= S_SC_CMP;
        end
        S_SC_CMP: begin
          if (hit) begin
            if (emit_ok) begin
              res_valid      <= 1'b1;
              res_kind       <= KIND_ACCEPT;
              res_slot       <= scan_slot;
              res_off        <= mem_rdata.offset;
              res_len        <= mem_rdata.len;
              res_done_bytes <= delivered;
              res_done       <= 1'b0;
              res_last       <= !(scan_slot == head || rcv[head]);
              rcv[scan_slot] <= 1'b1;
              st             <= S_DCHK;
            end
          end else if (scan_end) begin
            st <= S_DCHK;
          end else begin
            idx <= idx + COUNT_W'(1);
            st  <= S_SC_RD;
          end
        end
        S_DCHK: begin
          st <= (win_count != '0 && rcv[head]) ? S_DEMIT : S_IDLE;
        end
        S_DEMIT: begin
          if (emit_ok) begin
            res_valid      <= 1'b1;
            res_kind       <= KIND_DELIVER;
            res_slot       <= head;
            res_off        <= mem_rdata.offset;
            res_len        <= mem_rdata.len;
            res_done_bytes <= deliv_sum;
            res_done       <= (win_count == COUNT_W'(1)) && !need_more;
            res_last       <= !need_more &&
                              !(win_count > COUNT_W'(1) && rcv[head_plus1]);
            delivered      <= deliv_sum;
            rcv[head]      <= 1'b0;
            head           <= head_plus1;
            win_count      <= win_count - COUNT_W'(1);
            open_ret       <= 1'b1;
            st             <= need_more ? S_OPEN : S_DCHK;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    win_count <= Cap)
    else $error("window count above capacity");

  a_deliver_pops: assert property (@(posedge clk) disable iff (rst)
    (st == S_DEMIT && emit_ok) |=> win_count == $past(win_count) - COUNT_W'(1))
    else $error("delivery did not shrink the window");

  a_idle_head_clear: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE && win_count != '0) |-> !rcv[head])
    else $error("received head segment left undelivered");

  a_open_advances: assert property (@(posedge clk) disable iff (rst)
    (st == S_OPEN && can_open && emit_ok) |=> req_bytes != $past(req_bytes))
    else $error("segment opened without advancing requested bytes");

endmodule

FILE: src/sliding_window_segment_fetcher.sv
// ----------------------------------------------------------------------------
// sliding_window_segment_fetcher
// Receive window of a selective-repeat file fetch: issues get requests,
// accepts matching data headers and delivers segments in order.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        contents
//  item      in   valid/ready      req_type, sender, header_ok, offset, length
//  result    out  valid/ready      kind, slot, segment, bytes_done, done, last
//  cfg       in   cfg_we           cfg_index, cfg_data (no read-back)
//
//  One item is handled at a time; item.ready is high only while idle.
//  Start: get requests go out until the window is full or the file is asked for.
//  Timeout: each window entry is read, then its get request is emitted again.
//  Data: each slot scanned is read, then compared; each delivery checks the head,
//  emits and refills the window. A match away from the head delivers nothing;
//  the read steps come from the single registered read port of the slot table.
//  Result stalls hold the sequencer; a finished result waits in its register.
//  rst clears config and window state; the slot table is not cleared, as every
//  entry inside the window is written when its segment is opened.
// ----------------------------------------------------------------------------
module sliding_window_segment_fetcher #(
  parameter int WINDOW        = swsf_pkg::WINDOW_DEF,
  parameter int SEGMENT_BYTES = swsf_pkg::SEGMENT_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [swsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swsf_pkg::CFG_DATA_W-1:0]  cfg_data,
  swsf_in_if.sink                          item,
  swsf_out_if.source                       result
);
  import swsf_pkg::*;

  cfg_t        cfg;
  mem_req_t    mem_req;
  slot_entry_t mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILE_SIZE:   cfg.file_size   <= cfg_data[OFF_W-1:0];
        CFG_SERVER_ADDR: cfg.server_addr <= cfg_data[ADDR_W-1:0];
        CFG_SERVER_PORT: cfg.server_port <= cfg_data[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  swsf_seq #(
    .WINDOW        (WINDOW),
    .SEGMENT_BYTES (SEGMENT_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .result    (result),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  swsf_slot_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule
